// ===== hdl/totp_pkg.sv =====
// ----------------------------------------------------------------------------
// TOTP package
// Shared types and constants for the HMAC-SHA1 six-digit code generator.
// ----------------------------------------------------------------------------
`default_nettype none

package totp_pkg;

	localparam int KEY_WORDS   = 8;
	localparam int ADDR_W      = 6;
	localparam int DATA_W      = 64;
	localparam int CNT_W       = 7;
	localparam int DIV_STEPS   = 4;
	localparam int MOD_STEPS   = 2;

	localparam logic [5:0]  STEP_SECONDS = 6'd30;
	localparam logic [31:0] CODE_MODULUS = 32'd1000000;
	localparam logic [31:0] IPAD_WORD    = 32'h36363636;
	localparam logic [31:0] OPAD_WORD    = 32'h5c5c5c5c;
	localparam logic [31:0] PAD_WORD     = 32'h80000000;
	localparam logic [31:0] INNER_BITS   = 32'd576;
	localparam logic [31:0] OUTER_BITS   = 32'd672;

	// ceil(2^26 / 30): exact quotient for any 21-bit partial dividend below 30 * 2^16
	localparam logic [21:0] DIV_RECIP    = 22'd2236963;
	// ceil(2^50 / 1000000): exact quotient for any 31-bit value
	localparam logic [30:0] MOD_RECIP    = 31'd1125899907;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	// block order within one code
	localparam logic [1:0] BLK_IKEY = 2'd0;
	localparam logic [1:0] BLK_IMSG = 2'd1;
	localparam logic [1:0] BLK_OKEY = 2'd2;
	localparam logic [1:0] BLK_OMSG = 2'd3;

	typedef logic [KEY_WORDS-1:0][63:0] key_bank_t;

	typedef struct packed {
		logic             load_in;
		logic             div_step;
		logic             blk_load;
		logic             round;
		logic             fin_add;
		logic [1:0]       blk_sel;
		logic [CNT_W-1:0] rnd;
		logic             trunc;
		logic             mod_step;
		logic             mod_fix;
		logic             out_load;
	} totp_cmd_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

endpackage

`default_nettype wire

// ===== hdl/totp_datapath.sv =====
// ----------------------------------------------------------------------------
// TOTP datapath
// Reciprocal divide by 30 over 16-bit digits, one SHA-1 round per cycle,
// truncation and a two-step reciprocal modulo.
// ----------------------------------------------------------------------------
`default_nettype none

module totp_datapath (
	input  wire logic               clk,
	input  wire totp_pkg::totp_cmd_t cmd,
	input  wire totp_pkg::key_bank_t key,
	input  wire logic [63:0]        unix_seconds,
	output logic [19:0]             code
);
	import totp_pkg::*;

	logic [63:0]  num_q;
	logic [4:0]   rem_q;
	logic [31:0]  h_q [5];
	logic [31:0]  inner_q [5];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [31:0]  w_q [16];
	logic [30:0]  bin_q;
	logic [11:0]  quo_q;
	logic [19:0]  code_q;

	logic [20:0]  div_n;
	logic [42:0]  div_prod;
	logic [15:0]  div_q;
	logic [20:0]  div_back;
	logic [31:0]  blk_w [16];
	logic [31:0]  f, k, tmp, w_new;
	logic [159:0] dig;
	logic [31:0]  sel;
	logic [61:0]  mod_prod;
	logic [31:0]  mod_back;

	// one 16-bit digit per step, remainder carried into the next digit
	assign div_n    = {rem_q, num_q[63:48]};
	assign div_prod = 43'(div_n) * 43'(DIV_RECIP);
	assign div_q    = div_prod[41:26];
	assign div_back = 21'(div_q) * 21'(STEP_SECONDS);

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			blk_w[i] = '0;
		end
		case (cmd.blk_sel)
			BLK_IKEY, BLK_OKEY: begin
				for (int i = 0; i < KEY_WORDS; i++) begin
					blk_w[2*i]   = key[i][63:32] ^
						((cmd.blk_sel == BLK_IKEY) ? IPAD_WORD : OPAD_WORD);
					blk_w[2*i+1] = key[i][31:0] ^
						((cmd.blk_sel == BLK_IKEY) ? IPAD_WORD : OPAD_WORD);
				end
			end
			BLK_IMSG: begin
				blk_w[0]  = num_q[63:32];
				blk_w[1]  = num_q[31:0];
				blk_w[2]  = PAD_WORD;
				blk_w[15] = INNER_BITS;
			end
			default: begin
				for (int i = 0; i < 5; i++) begin
					blk_w[i] = inner_q[i];
				end
				blk_w[5]  = PAD_WORD;
				blk_w[15] = OUTER_BITS;
			end
		endcase
	end

	always_comb begin
		if (cmd.rnd < CNT_W'(20)) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (cmd.rnd < CNT_W'(40)) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (cmd.rnd < CNT_W'(60)) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
		tmp   = rotl(a_q, 5) + f + e_q + k + w_q[0];
		w_new = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
	end

	assign dig = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};

	always_comb begin
		sel = '0;
		for (int i = 0; i < 16; i++) begin
			if (h_q[4][3:0] == 4'(i)) begin
				sel = dig[159-8*i -: 32];
			end
		end
	end

	// first step registers the quotient, second step subtracts it back out
	assign mod_prod = 62'(bin_q) * 62'(MOD_RECIP);
	assign mod_back = 32'(quo_q) * CODE_MODULUS;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			num_q  <= unix_seconds;
			rem_q  <= '0;
			h_q[0] <= H0;
			h_q[1] <= H1;
			h_q[2] <= H2;
			h_q[3] <= H3;
			h_q[4] <= H4;
		end
		if (cmd.div_step) begin
			num_q <= {num_q[47:0], div_q};
			rem_q <= 5'(div_n - div_back);
		end
		if (cmd.blk_load) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= blk_w[i];
			end
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end
		if (cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
			e_q <= d_q;
			d_q <= c_q;
			c_q <= rotl(b_q, 30);
			b_q <= a_q;
			a_q <= tmp;
		end
		if (cmd.fin_add) begin
			if (cmd.blk_sel == BLK_IMSG) begin
				// keep inner digest, restart chaining for the outer hash
				inner_q[0] <= h_q[0] + a_q;
				inner_q[1] <= h_q[1] + b_q;
				inner_q[2] <= h_q[2] + c_q;
				inner_q[3] <= h_q[3] + d_q;
				inner_q[4] <= h_q[4] + e_q;
				h_q[0] <= H0;
				h_q[1] <= H1;
				h_q[2] <= H2;
				h_q[3] <= H3;
				h_q[4] <= H4;
			end else begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end
		end
		if (cmd.trunc) begin
			bin_q <= sel[30:0];
		end
		if (cmd.mod_step && !cmd.mod_fix) begin
			quo_q <= mod_prod[61:50];
		end
		if (cmd.mod_step && cmd.mod_fix) begin
			bin_q <= 31'({1'b0, bin_q} - mod_back);
		end
		if (cmd.out_load) begin
			code_q <= bin_q[19:0];
		end
	end

	assign code = code_q;

endmodule

`default_nettype wire

// ===== hdl/totp_ctrl.sv =====
// ----------------------------------------------------------------------------
// TOTP controller
// Sequences divide, four SHA-1 compressions, truncation, modulo and output.
// ----------------------------------------------------------------------------
`default_nettype none

module totp_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output totp_pkg::totp_cmd_t     cmd
);
	import totp_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_DIV   = 8'b0000_0010,
		ST_LOAD  = 8'b0000_0100,
		ST_ROUND = 8'b0000_1000,
		ST_ADD   = 8'b0001_0000,
		ST_TRUNC = 8'b0010_0000,
		ST_MOD   = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       blk_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd          = '0;
		cmd.blk_sel  = blk_q;
		cmd.rnd      = cnt_q;
		cmd.mod_fix  = (cnt_q == '0);
		cmd.load_in  = (state_q == ST_IDLE) && in_valid;
		cmd.div_step = (state_q == ST_DIV);
		cmd.blk_load = (state_q == ST_LOAD);
		cmd.round    = (state_q == ST_ROUND);
		cmd.fin_add  = (state_q == ST_ADD);
		cmd.trunc    = (state_q == ST_TRUNC);
		cmd.mod_step = (state_q == ST_MOD);
		cmd.out_load = (state_q == ST_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			blk_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_LOAD;
						blk_q   <= BLK_IKEY;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_LOAD: begin
					state_q <= ST_ROUND;
					cnt_q   <= '0;
				end
				ST_ROUND: begin
					if (cnt_q == CNT_W'(79)) begin
						state_q <= ST_ADD;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_ADD: begin
					if (blk_q == BLK_OMSG) begin
						state_q <= ST_TRUNC;
					end else begin
						state_q <= ST_LOAD;
						blk_q   <= blk_q + 1'b1;
					end
				end
				ST_TRUNC: begin
					state_q <= ST_MOD;
					cnt_q   <= CNT_W'(MOD_STEPS - 1);
				end
				ST_MOD: begin
					if (cnt_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/totp_hmac_sha1_code.sv =====
// Sequence: from item accept to code valid, 4 divide steps, four SHA-1
// blocks on one shared round unit, truncation, 2 modulo steps and the
// output load, which waits only while a stalled code blocks it.
// One item at a time; a new item is taken while the previous code still
// waits in the output register.
// Reset: arst_n clears control and the key registers asynchronously.
// ----------------------------------------------------------------------------
// TOTP HMAC-SHA1 code generator
// Six-digit time-based one-time code from a Unix time and a 64-byte key.
// ----------------------------------------------------------------------------
`default_nettype none

module totp_hmac_sha1_code (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [63:0]                   unix_seconds,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [19:0]                        code,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [totp_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [totp_pkg::DATA_W-1:0]   pwdata,
	output logic [totp_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);
	import totp_pkg::*;

	key_bank_t key_q;
	totp_cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (psel && penable && pwrite) begin
			key_q[paddr[5:3]] <= pwdata;
		end
	end

	assign prdata = key_q[paddr[5:3]];
	assign pready = 1'b1;

	totp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	totp_datapath u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.key          (key_q),
		.unix_seconds (unix_seconds),
		.code         (code)
	);

endmodule

`default_nettype wire

// ===== hdl/totp_checker.sv =====
// ----------------------------------------------------------------------------
// TOTP port checker
// Watches the item channels of the code generator over time.
// ----------------------------------------------------------------------------
`default_nettype none

module totp_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [19:0] code
);

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(code))
		else $error("stalled result changed");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> code < 20'd1000000)
		else $error("code out of range");

	// finishing an item frees the input side at once
	a_free_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("input still busy after result");

endmodule

bind totp_hmac_sha1_code totp_checker u_chk (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// TOTP code generator testbench
// Drives Unix times through the block under several keys and compares each
// six-digit code against an HMAC-SHA1 dynamic-truncation predictor.
// ----------------------------------------------------------------------------
`default_nettype none

class code_board;
	logic [19:0] pending[$];
	int errors;
	int checked;

	function new();
		errors = 0;
		checked = 0;
	endfunction

	function void note_time(logic [19:0] predicted);
		pending.push_back(predicted);
	endfunction

	function void check_code(logic [19:0] actual);
		logic [19:0] want;
		if (pending.size() == 0) begin
			$error("code: no item waiting, actual %0d", actual);
			errors++;
		end else begin
			want = pending.pop_front();
			checked++;
			if (want !== actual) begin
				$error("code: expected %0d actual %0d", want, actual);
				errors++;
			end
		end
	endfunction
endclass

module tb_top;
	import totp_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] unix_seconds;
	logic        out_valid;
	logic        out_stall;
	logic [19:0] code;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic        pready;

	logic [63:0] key_shadow[KEY_WORDS];
	code_board   board;
	int          sent;

	totp_hmac_sha1_code u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .unix_seconds(unix_seconds),
		.out_valid(out_valid), .out_stall(out_stall), .code(code),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] rol(logic [31:0] x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void sha1_block(ref logic [31:0] h[5], input logic [31:0] blk[16]);
		logic [31:0] w[80];
		logic [31:0] a, b, c, d, e, f, k, t;
		a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
		for (int i = 0; i < 16; i++) w[i] = blk[i];
		for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin f = (b & c) | (~b & d); k = 32'h5A827999; end
			else if (i < 40) begin f = b ^ c ^ d; k = 32'h6ED9EBA1; end
			else if (i < 60) begin f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC; end
			else begin f = b ^ c ^ d; k = 32'hCA62C1D6; end
			t = rol(a, 5) + f + e + k + w[i];
			e = d; d = c; c = rol(b, 30); b = a; a = t;
		end
		h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
	endfunction

	function automatic void hash_key(ref logic [31:0] h[5], input logic [31:0] pad);
		logic [31:0] blk[16];
		h[0] = 32'h67452301; h[1] = 32'hEFCDAB89; h[2] = 32'h98BADCFE;
		h[3] = 32'h10325476; h[4] = 32'hC3D2E1F0;
		for (int i = 0; i < KEY_WORDS; i++) begin
			blk[2*i]   = key_shadow[i][63:32] ^ pad;
			blk[2*i+1] = key_shadow[i][31:0] ^ pad;
		end
		sha1_block(h, blk);
	endfunction

	function automatic logic [19:0] totp_code(logic [63:0] secs);
		logic [63:0] step;
		logic [31:0] inner[5], outer[5], blk[16], bin;
		logic [7:0]  dig[20];
		int off;
		step = secs / 64'd30;
		hash_key(inner, 32'h36363636);
		foreach (blk[i]) blk[i] = '0;
		blk[0] = step[63:32]; blk[1] = step[31:0]; blk[2] = 32'h80000000; blk[15] = 32'd576;
		sha1_block(inner, blk);
		hash_key(outer, 32'h5c5c5c5c);
		foreach (blk[i]) blk[i] = '0;
		for (int i = 0; i < 5; i++) blk[i] = inner[i];
		blk[5] = 32'h80000000; blk[15] = 32'd672;
		sha1_block(outer, blk);
		for (int i = 0; i < 20; i++) dig[i] = 8'(outer[i/4] >> (24 - 8*(i%4)));
		off = int'(dig[19][3:0]);
		bin = {1'b0, dig[off][6:0], dig[off+1], dig[off+2], dig[off+3]};
		return 20'(bin % 32'd1000000);
	endfunction

	task automatic write_key(int idx, logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_W'(8 * idx); pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx < KEY_WORDS) key_shadow[idx] = value;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// valid stays up between back-to-back items; drop it only for a gap
	task automatic send_time(logic [63:0] secs);
		int gap;
		gap = $urandom_range(0, 13) * ($urandom_range(0, 3) == 0 ? 0 : 1);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		unix_seconds <= secs;
		do @(posedge clk); while (in_stall);
		board.note_time(totp_code(secs));
		sent++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// receiver: hold stall a random number of cycles after each accepted code
	initial begin
		int hold;
		hold = $urandom_range(0, 13);
		out_stall = (hold != 0);
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				board.check_code(code);
				hold = $urandom_range(0, 13);
			end else if (hold != 0) begin
				hold--;
			end
			out_stall <= (hold != 0);
		end
	end

	initial begin
		#200000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		logic [63:0] k;
		board = new();
		sent = 0;
		arst_n = 1'b0; in_valid = 1'b0; unix_seconds = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		foreach (key_shadow[i]) key_shadow[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// zero key, edge times
		send_time(64'd0);
		send_time(64'd29);
		send_time(64'd30);
		send_time(64'hFFFF_FFFF_FFFF_FFFF);
		send_time(64'hFFFF_FFFF_FFFF_FFE1);
		drain();
		// RFC test key "12345678901234567890"
		write_key(0, 64'h3132333435363738);
		write_key(1, 64'h3930313233343536);
		write_key(2, 64'h3738393000000000);
		for (int i = 3; i < KEY_WORDS; i++) write_key(i, '0);
		send_time(64'd59);
		send_time(64'd1111111109);
		send_time(64'd1234567890);
		send_time(64'd20000000000);
		drain();
		// all-ones key
		for (int i = 0; i < KEY_WORDS; i++) write_key(i, '1);
		send_time(64'd0);
		send_time(64'hFFFF_FFFF_FFFF_FFFF);
		for (int b = 0; b < 64; b += 8) send_time(64'h1 << b | (64'h1 << (b + 7)));
		drain();
		for (int phase = 0; phase < 6; phase++) begin
			for (int i = 0; i < KEY_WORDS; i++) begin
				k = (phase == 5) ? '0 : rand64();
				if (i > phase + 2) k = '0;
				write_key(i, k);
			end
			for (int n = 0; n < 90; n++) begin
				case ($urandom_range(0, 3))
					0: send_time(64'($urandom()));
					1: send_time(rand64());
					2: send_time(64'd1700000000 + 64'($urandom_range(0, 100000)));
					default: send_time(~64'($urandom_range(0, 200)));
				endcase
			end
			drain();
		end
		$display("Sent %0d times over 9 key settings; %0d codes checked.", sent, board.checked);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

`default_nettype wire
